/* rtl/bfqd_pkg.sv */
package bfqd_pkg;

  localparam int VEC_W = 32;
  localparam int QUAT_W = 16;
  localparam int OUT_W = 48;
  localparam int VEC_FRAC = 16;
  localparam int L2_W = 2 * QUAT_W + 1;

  localparam int CFG_COUNT = 7;
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = CFG_IDX_W'(CFG_COUNT);
  localparam logic [CFG_IDX_W-1:0] REG_DENSITY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIN_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIN_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIN_Z = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ANG_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ANG_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ANG_Z = 3'd6;
  localparam logic [VEC_W-1:0] DENSITY_RESET = 32'h0401_0000;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_ZERO = 2'd1,
    STATUS_SAT  = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0][VEC_W-1:0]  lin;
    logic [2:0][VEC_W-1:0]  ang;
    logic [3:0][QUAT_W-1:0] quat;
    logic [L2_W-1:0]        l2;
    logic                   zero;
  } item_t;

endpackage

/* rtl/bfqd_front.sv */
module bfqd_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  logic [31:0]          lin_vel_x,
  input  logic [31:0]          lin_vel_y,
  input  logic [31:0]          lin_vel_z,
  input  logic [31:0]          ang_vel_x,
  input  logic [31:0]          ang_vel_y,
  input  logic [31:0]          ang_vel_z,
  input  logic [15:0]          quat_x,
  input  logic [15:0]          quat_y,
  input  logic [15:0]          quat_z,
  input  logic [15:0]          quat_w,
  output logic                 push,
  output bfqd_pkg::item_t      item
);
  import bfqd_pkg::*;

  logic [3:0][QUAT_W-1:0] quat_in;
  logic [2*QUAT_W-1:0]    sq [4];
  logic [L2_W-1:0]        l2_next;
  logic                   take;

  assign quat_in = {quat_w, quat_z, quat_y, quat_x};
  assign take = start && !busy;

  // squared length of the raw quaternion
  always_comb begin
    l2_next = '0;
    for (int i = 0; i < 4; i++) begin
      sq[i] = $signed(quat_in[i]) * $signed(quat_in[i]);
      l2_next = l2_next + {1'b0, sq[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      push <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.lin  <= {lin_vel_z, lin_vel_y, lin_vel_x};
      item.ang  <= {ang_vel_z, ang_vel_y, ang_vel_x};
      item.quat <= quat_in;
      item.l2   <= l2_next;
      item.zero <= (l2_next == '0);
    end
  end

endmodule

/* rtl/bfqd_queue.sv */
module bfqd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  bfqd_pkg::item_t push_item,
  output logic            full,
  output logic            head_valid,
  output bfqd_pkg::item_t head_item
);
  import bfqd_pkg::*;

  item_t             slot [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              pop;

  // the back end never stalls, so the head leaves whenever it is there
  assign head_valid = (count != '0);
  assign pop = head_valid;
  assign full = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head_item = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_item;
    end
  end

endmodule

/* rtl/bfqd_norm.sv */
module bfqd_norm (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  bfqd_pkg::item_t  in_item,
  output logic             out_valid,
  output bfqd_pkg::item_t  out_item,
  output logic [3:0][31:0] unit
);
  import bfqd_pkg::*;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS = 31;
  localparam int NORM_DEPTH = SQRT_STEPS + DIV_STEPS;

  typedef struct packed {
    item_t            item;
    logic [33:0]      rem;
    logic [31:0]      root;
    logic [3:0][31:0] drem;
    logic [3:0][30:0] quo;
  } norm_t;

  norm_t               st [NORM_DEPTH+1];
  logic [NORM_DEPTH:0] vld;
  logic [31:0]         mq [4];

  function automatic logic [15:0] mag16(logic [15:0] q);
    return q[15] ? -q : q;
  endfunction

  // one root bit per step, then one quotient bit per step on all four lanes
  function automatic norm_t step(norm_t a, int k);
    norm_t       b;
    logic [63:0] n;
    logic [35:0] r2;
    logic [35:0] trial;
    logic [31:0] base;
    logic [32:0] rd;
    b = a;
    if (k < SQRT_STEPS) begin
      n = {1'b0, a.item.l2, 30'd0};
      r2 = {a.rem, n[63-2*k -: 2]};
      trial = {2'b00, a.root, 2'b01};
      if (r2 >= trial) begin
        b.rem = 34'(r2 - trial);
        b.root = {a.root[30:0], 1'b1};
      end else begin
        b.rem = r2[33:0];
        b.root = {a.root[30:0], 1'b0};
      end
    end else begin
      for (int i = 0; i < 4; i++) begin
        base = (k == SQRT_STEPS) ? {2'b00, mag16(a.item.quat[i]), 14'd0} : a.drem[i];
        rd = {base, 1'b0};
        if (rd >= {1'b0, a.root}) begin
          b.drem[i] = 32'(rd - {1'b0, a.root});
          b.quo[i] = {a.quo[i][29:0], 1'b1};
        end else begin
          b.drem[i] = rd[31:0];
          b.quo[i] = {a.quo[i][29:0], 1'b0};
        end
      end
    end
    return b;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NORM_DEPTH-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    st[0].item <= in_item;
    st[0].rem <= '0;
    st[0].root <= '0;
    st[0].drem <= '0;
    st[0].quo <= '0;
    for (int k = 0; k < NORM_DEPTH; k++) begin
      st[k+1] <= step(st[k], k);
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mq[i] = {1'b0, st[NORM_DEPTH].quo[i]};
      unit[i] = st[NORM_DEPTH].item.quat[i][15] ? -mq[i] : mq[i];
    end
  end

  assign out_valid = vld[NORM_DEPTH];
  assign out_item = st[NORM_DEPTH].item;

endmodule

/* rtl/bfqd_back.sv */
module bfqd_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  bfqd_pkg::item_t    in_item,
  input  logic [3:0][31:0]   unit,
  input  logic [31:0]        density,
  input  logic [2:0][31:0]   lin_coef,
  input  logic [2:0][31:0]   ang_coef,
  output logic               out_valid,
  output logic [2:0][47:0]   force_w,
  output logic [2:0][47:0]   torque_w,
  output bfqd_pkg::status_t  status
);
  import bfqd_pkg::*;

  localparam int PA [9] = '{0, 1, 2, 0, 0, 1, 3, 3, 3};
  localparam int PB [9] = '{0, 1, 2, 1, 2, 2, 0, 1, 2};
  localparam logic signed [35:0] ONE30 = 36'sd1073741824;
  localparam logic [46:0] LIM47 = '1;
  localparam logic signed [53:0] MAX48 = 54'sd140737488355327;
  localparam logic signed [53:0] MIN48 = -54'sd140737488355328;

  logic [10:0] vld;
  logic [10:0] zro;

  logic signed [63:0] qprod [9];
  logic signed [33:0] p1 [9];
  logic signed [31:0] vel1 [2][3];
  logic signed [31:0] vel2 [2][3];
  logic signed [35:0] rmat [9];
  logic signed [35:0] rdl [8][9];
  logic signed [67:0] fprod [2][9];
  logic signed [35:0] t3 [2][9];
  logic signed [37:0] vloc [2][3];
  logic [37:0]        mg [2][3];
  logic [35:0]        mhh [2][3];
  logic [37:0]        mhl [2][3];
  logic [39:0]        mll [2][3];
  logic [63:0]        kp [2][3];
  logic [5:0]         neg5, nz5, neg6, nz6, neg7, nz7, neg8, nz8;
  logic [76:0]        v2sum [2][3];
  logic [60:0]        v2 [2][3];
  logic [46:0]        k6 [2][3];
  logic [52:0]        hh [2][3];
  logic [53:0]        hl [2][3];
  logic [53:0]        lh [2][3];
  logic [54:0]        ll [2][3];
  logic [107:0]       dsum [2][3];
  logic [46:0]        dmag [2][3];
  logic [5:0]         sat8, sat9, sat10, sat11;
  logic signed [47:0] f9 [2][3];
  logic signed [51:0] phi [2][9];
  logic signed [68:0] plo [2][9];
  logic signed [84:0] wide [2][9];
  logic signed [51:0] w11 [2][9];
  logic signed [53:0] wsum [2][3];
  logic [47:0]        wv [2][3];
  logic               wsat;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      out_valid <= 1'b0;
    end else begin
      vld <= {vld[9:0], in_valid};
      out_valid <= vld[10];
    end
  end

  // quaternion products and rotation matrix
  always_comb begin
    for (int n = 0; n < 9; n++) begin
      qprod[n] = $signed(unit[PA[n]]) * $signed(unit[PB[n]]);
    end
  end

  always_ff @(posedge clk) begin
    zro <= {zro[9:0], in_item.zero};
    for (int n = 0; n < 9; n++) begin
      p1[n] <= 34'(qprod[n] >>> 29);
    end
    for (int i = 0; i < 3; i++) begin
      vel1[0][i] <= $signed(in_item.lin[i]);
      vel1[1][i] <= $signed(in_item.ang[i]);
    end
    vel2 <= vel1;
    rdl[0] <= rmat;
    for (int d = 1; d < 8; d++) begin
      rdl[d] <= rdl[d-1];
    end
  end

  always_comb begin
    rmat[0] = ONE30 - (36'(p1[1]) + 36'(p1[2]));
    rmat[1] = 36'(p1[3]) - 36'(p1[8]);
    rmat[2] = 36'(p1[4]) + 36'(p1[7]);
    rmat[3] = 36'(p1[3]) + 36'(p1[8]);
    rmat[4] = ONE30 - (36'(p1[0]) + 36'(p1[2]));
    rmat[5] = 36'(p1[5]) - 36'(p1[6]);
    rmat[6] = 36'(p1[4]) - 36'(p1[7]);
    rmat[7] = 36'(p1[5]) + 36'(p1[6]);
    rmat[8] = ONE30 - (36'(p1[0]) + 36'(p1[1]));
  end

  // world to body
  always_comb begin
    for (int v = 0; v < 2; v++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          fprod[v][i*3+j] = rdl[0][j*3+i] * vel2[v][j];
        end
      end
    end
  end

  // drag magnitude
  always_comb begin
    for (int v = 0; v < 2; v++) begin
      for (int i = 0; i < 3; i++) begin
        mg[v][i] = vloc[v][i][37] ? 38'(-vloc[v][i]) : 38'(vloc[v][i]);
        v2sum[v][i] = {1'b0, mhh[v][i], 40'd0} + {18'd0, mhl[v][i], 21'd0}
                    + {37'd0, mll[v][i]};
        dsum[v][i] = {hh[v][i], 55'd0} + {30'd0, hl[v][i], 24'd0}
                   + {23'd0, lh[v][i], 31'd0} + {53'd0, ll[v][i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int v = 0; v < 2; v++) begin
      for (int i = 0; i < 3; i++) begin
        t3[v][i*3]   <= 36'(fprod[v][i*3] >>> 30);
        t3[v][i*3+1] <= 36'(fprod[v][i*3+1] >>> 30);
        t3[v][i*3+2] <= 36'(fprod[v][i*3+2] >>> 30);
        vloc[v][i] <= 38'(t3[v][i*3]) + 38'(t3[v][i*3+1]) + 38'(t3[v][i*3+2]);
        mhh[v][i] <= mg[v][i][37:20] * mg[v][i][37:20];
        mhl[v][i] <= mg[v][i][37:20] * mg[v][i][19:0];
        mll[v][i] <= mg[v][i][19:0] * mg[v][i][19:0];
        kp[v][i] <= density * ((v == 0) ? lin_coef[i] : ang_coef[i]);
        neg5[v*3+i] <= vloc[v][i][37];
        nz5[v*3+i] <= (vloc[v][i] != '0);
        v2[v][i] <= v2sum[v][i][76:VEC_FRAC];
        k6[v][i] <= kp[v][i][63:VEC_FRAC+1];
        hh[v][i] <= k6[v][i][46:24] * v2[v][i][60:31];
        hl[v][i] <= k6[v][i][46:24] * v2[v][i][30:0];
        lh[v][i] <= k6[v][i][23:0] * v2[v][i][60:31];
        ll[v][i] <= k6[v][i][23:0] * v2[v][i][30:0];
        sat8[v*3+i] <= |dsum[v][i][107:VEC_FRAC+47];
        dmag[v][i] <= (|dsum[v][i][107:VEC_FRAC+47]) ? LIM47
                      : dsum[v][i][VEC_FRAC+46:VEC_FRAC];
        if (!nz8[v*3+i]) begin
          f9[v][i] <= '0;
        end else if (neg8[v*3+i]) begin
          f9[v][i] <= $signed({1'b0, dmag[v][i]});
        end else begin
          f9[v][i] <= -$signed({1'b0, dmag[v][i]});
        end
      end
    end
    neg6 <= neg5;
    nz6 <= nz5;
    neg7 <= neg6;
    nz7 <= nz6;
    neg8 <= neg7;
    nz8 <= nz7;
    sat9 <= sat8;
    sat10 <= sat9;
    sat11 <= sat10;
  end

  // body to world, force and torque split into high and low partial products
  always_comb begin
    for (int v = 0; v < 2; v++) begin
      for (int n = 0; n < 9; n++) begin
        wide[v][n] = $signed({phi[v][n], 32'd0}) + plo[v][n];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int v = 0; v < 2; v++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          phi[v][i*3+j] <= rdl[7][i*3+j] * $signed(f9[v][j][47:32]);
          plo[v][i*3+j] <= rdl[7][i*3+j] * $signed({1'b0, f9[v][j][31:0]});
        end
      end
      for (int n = 0; n < 9; n++) begin
        w11[v][n] <= 52'(wide[v][n] >>> 30);
      end
    end
  end

  always_comb begin
    wsat = 1'b0;
    for (int v = 0; v < 2; v++) begin
      for (int i = 0; i < 3; i++) begin
        wsum[v][i] = 54'(w11[v][i*3]) + 54'(w11[v][i*3+1]) + 54'(w11[v][i*3+2]);
        if (wsum[v][i] > MAX48) begin
          wv[v][i] = MAX48[47:0];
          wsat = 1'b1;
        end else if (wsum[v][i] < MIN48) begin
          wv[v][i] = MIN48[47:0];
          wsat = 1'b1;
        end else begin
          wv[v][i] = wsum[v][i][47:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      force_w[i] <= zro[10] ? '0 : wv[0][i];
      torque_w[i] <= zro[10] ? '0 : wv[1][i];
    end
    if (zro[10]) begin
      status <= STATUS_ZERO;
    end else if (wsat || (|sat11)) begin
      status <= STATUS_SAT;
    end else begin
      status <= STATUS_OK;
    end
  end

endmodule

/* rtl/body_frame_quadratic_drag.sv */
// One body per start transfer, one result per body. An item is taken at every clock edge where
// start is high and busy is low, so a new body can enter on every cycle; each result appears
// 78 cycles after its start transfer, in order, with done high for exactly one cycle, and
// must be taken then since the result side has no stall. The latency is set by the fully
// pipelined normalizer, a 32-stage square root followed by a 31-stage divider, and by the
// 12-stage rotate, drag and rotate-back pipeline. Status is 0 for ok, 1 for a zero quaternion
// (all forces and torques zero) and 2 when any drag or world value saturated. Registers are
// written through cfg_wr_en, cfg_index and cfg_data; an index above 6 is ignored.
module body_frame_quadratic_drag (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [31:0] lin_vel_x,
  input  logic [31:0] lin_vel_y,
  input  logic [31:0] lin_vel_z,
  input  logic [31:0] ang_vel_x,
  input  logic [31:0] ang_vel_y,
  input  logic [31:0] ang_vel_z,
  input  logic [15:0] quat_x,
  input  logic [15:0] quat_y,
  input  logic [15:0] quat_z,
  input  logic [15:0] quat_w,
  output logic        done,
  output logic [47:0] force_x,
  output logic [47:0] force_y,
  output logic [47:0] force_z,
  output logic [47:0] torque_x,
  output logic [47:0] torque_y,
  output logic [47:0] torque_z,
  output logic [1:0]  status
);
  import bfqd_pkg::*;

  localparam int LATENCY = 78;

  logic [VEC_W-1:0]    cfg_reg [CFG_COUNT];
  logic                push;
  item_t               front_item;
  logic                head_valid;
  item_t               head_item;
  logic                norm_valid;
  item_t               norm_item;
  logic [3:0][31:0]    unit;
  logic [2:0][47:0]    force_w;
  logic [2:0][47:0]    torque_w;
  status_t             back_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CFG_COUNT; i++) begin
        cfg_reg[i] <= '0;
      end
      cfg_reg[REG_DENSITY] <= DENSITY_RESET;
    end else if (cfg_wr_en && cfg_index < CFG_LIMIT) begin
      cfg_reg[cfg_index] <= cfg_data;
    end
  end

  bfqd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .lin_vel_x (lin_vel_x),
    .lin_vel_y (lin_vel_y),
    .lin_vel_z (lin_vel_z),
    .ang_vel_x (ang_vel_x),
    .ang_vel_y (ang_vel_y),
    .ang_vel_z (ang_vel_z),
    .quat_x    (quat_x),
    .quat_y    (quat_y),
    .quat_z    (quat_z),
    .quat_w    (quat_w),
    .push      (push),
    .item      (front_item)
  );

  bfqd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (front_item),
    .full       (busy),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  bfqd_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (head_valid),
    .in_item   (head_item),
    .out_valid (norm_valid),
    .out_item  (norm_item),
    .unit      (unit)
  );

  bfqd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (norm_valid),
    .in_item   (norm_item),
    .unit      (unit),
    .density   (cfg_reg[REG_DENSITY]),
    .lin_coef  ({cfg_reg[REG_LIN_Z], cfg_reg[REG_LIN_Y], cfg_reg[REG_LIN_X]}),
    .ang_coef  ({cfg_reg[REG_ANG_Z], cfg_reg[REG_ANG_Y], cfg_reg[REG_ANG_X]}),
    .out_valid (done),
    .force_w   (force_w),
    .torque_w  (torque_w),
    .status    (back_status)
  );

  assign force_x = force_w[0];
  assign force_y = force_w[1];
  assign force_z = force_w[2];
  assign torque_x = torque_w[0];
  assign torque_y = torque_w[1];
  assign torque_z = torque_w[2];
  assign status = back_status;

  // fixed latency from start transfer to result
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |-> ##LATENCY done)
    else $error("result missing after fixed latency");

  // queue drains every cycle, so it never fills
  assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("queue filled");

  // zero orientation yields all-zero vectors
  assert property (@(posedge clk) disable iff (rst)
    (done && status == STATUS_ZERO) |-> (force_x == '0 && force_y == '0 && force_z == '0
      && torque_x == '0 && torque_y == '0 && torque_z == '0))
    else $error("zero orientation with nonzero result");

endmodule
